/* hdl/fcsb_pkg.sv */
package fcsb_pkg;
  localparam int unsigned CoordWidth   = 16;
  localparam int unsigned FractionBits = 8;
  localparam int unsigned PlaneCount   = 6;
  localparam int unsigned CornerCount  = 8;
  localparam int unsigned RegCount     = 7;
  localparam int unsigned AddrWidth    = 6;

  typedef enum logic [2:0] {
    RegPlane0 = 3'd0,
    RegPlane1 = 3'd1,
    RegPlane2 = 3'd2,
    RegPlane3 = 3'd3,
    RegPlane4 = 3'd4,
    RegPlane5 = 3'd5,
    RegSphere = 3'd6
  } reg_idx_e;

  typedef enum logic {
    OpSphere = 1'b0,
    OpBox    = 1'b1
  } op_e;
endpackage

/* hdl/fcsb_in_if.sv */
interface fcsb_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [47:0] sphere_centre;
  logic [14:0] sphere_radius;
  logic [47:0] corner_0;
  logic [47:0] corner_1;
  logic [47:0] corner_2;
  logic [47:0] corner_3;
  logic [47:0] corner_4;
  logic [47:0] corner_5;
  logic [47:0] corner_6;
  logic [47:0] corner_7;
  modport source (output valid, operation, sphere_centre, sphere_radius, corner_0, corner_1,
                  corner_2, corner_3, corner_4, corner_5, corner_6, corner_7, input ready);
  modport sink (input valid, operation, sphere_centre, sphere_radius, corner_0, corner_1,
                corner_2, corner_3, corner_4, corner_5, corner_6, corner_7, output ready);
endinterface

/* hdl/fcsb_out_if.sv */
interface fcsb_out_if;
  logic valid;
  logic ready;
  logic visible;
  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

/* hdl/frustum_cull_sphere_box.sv */
// Pipeline: four register stages (product, sum, compare, flag); the flag stage is the
// output register, so a result is valid once its item has passed through all four.
// Throughput: one item per cycle; the whole pipeline advances together and holds when
// the output register is full and not taken.
// Reset: rst_ni clears the valid bits and all plane and bounding sphere registers.
module frustum_cull_sphere_box #(
  parameter int unsigned COORD_WIDTH   = fcsb_pkg::CoordWidth,
  parameter int unsigned FRACTION_BITS = fcsb_pkg::FractionBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fcsb_pkg::AddrWidth-1:0] paddr,
  input  logic [63:0]                    pwdata,
  output logic [63:0]                    prdata,
  output logic                           pready,
  fcsb_in_if.sink                        in_if,
  fcsb_out_if.source                     out_if
);
  import fcsb_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned PW = 2 * CW + 1;   // product width
  localparam int unsigned SW = 2 * CW + 4;   // sum width
  localparam int unsigned NT = PlaneCount * CornerCount;

  logic [63:0] plane_q [PlaneCount];
  logic [63:0] sph_q;
  logic        wr_en;
  logic [2:0]  widx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PlaneCount; i++) plane_q[i] <= '0;
      sph_q <= '0;
    end else if (wr_en && paddr[2:0] == 3'd0) begin
      for (int i = 0; i < PlaneCount; i++)
        if (widx == 3'(i)) plane_q[i] <= pwdata;
      if (widx == RegSphere) sph_q <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (widx)
      RegPlane0: prdata = plane_q[0];
      RegPlane1: prdata = plane_q[1];
      RegPlane2: prdata = plane_q[2];
      RegPlane3: prdata = plane_q[3];
      RegPlane4: prdata = plane_q[4];
      RegPlane5: prdata = plane_q[5];
      RegSphere: prdata = sph_q;
      default:   prdata = '0;
    endcase
  end

  function automatic logic signed [CW-1:0] wd(input logic [63:0] v, input int unsigned k);
    wd = $signed(v[k*CW +: CW]);
  endfunction

  // pipeline control: advance when output slot is free or being taken
  logic adv;
  logic v1_q, v2_q, v3_q, v4_q;
  assign adv = !out_if.valid || out_if.ready;
  assign in_if.ready = adv;

  // stage 1: products
  logic signed [PW-1:0] p1_q [NT+PlaneCount][3];
  logic signed [PW-1:0] dsq1_q [3];
  logic signed [CW+1:0] rs1_q;
  logic                 op1_q, bsen1_q;
  logic signed [CW:0]   rad1_q;
  logic [47:0]          pts [CornerCount+1];

  assign pts[0] = in_if.corner_0;
  assign pts[1] = in_if.corner_1;
  assign pts[2] = in_if.corner_2;
  assign pts[3] = in_if.corner_3;
  assign pts[4] = in_if.corner_4;
  assign pts[5] = in_if.corner_5;
  assign pts[6] = in_if.corner_6;
  assign pts[7] = in_if.corner_7;
  assign pts[8] = in_if.sphere_centre;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int p = 0; p < PlaneCount; p++)
        for (int k = 0; k < 3; k++) begin
          for (int c = 0; c < CornerCount; c++)
            p1_q[p*CornerCount+c][k] <= PW'(wd(plane_q[p], k) * wd(64'(pts[c]), k));
          p1_q[NT+p][k] <= PW'(wd(plane_q[p], k) * wd(64'(pts[8]), k));
        end
      for (int k = 0; k < 3; k++)
        dsq1_q[k] <= PW'((CW+1)'(wd(sph_q, k)) - (CW+1)'(wd(64'(pts[8]), k)))
                     * PW'((CW+1)'(wd(sph_q, k)) - (CW+1)'(wd(64'(pts[8]), k)));
      rs1_q   <= (CW+2)'(wd(sph_q, 3)) + (CW+2)'(in_if.sphere_radius[CW-2:0]);
      rad1_q  <= (CW+1)'(in_if.sphere_radius[CW-2:0]);
      bsen1_q <= wd(sph_q, 3) > 0;
      op1_q   <= in_if.operation;
    end
  end

  // stage 2: sums, radius-sum square
  logic signed [SW-1:0]   dot2_q [NT+PlaneCount];
  logic signed [SW-1:0]   d22_q;
  logic signed [2*CW+4:0] rr2_q;
  logic signed [CW:0]     rad2_q;
  logic                   op2_q, bsen2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int t = 0; t < NT + PlaneCount; t++)
        dot2_q[t] <= SW'(p1_q[t][0]) + SW'(p1_q[t][1]) + SW'(p1_q[t][2]);
      d22_q   <= SW'(dsq1_q[0]) + SW'(dsq1_q[1]) + SW'(dsq1_q[2]);
      rr2_q   <= (2*CW+5)'(rs1_q * rs1_q);
      rad2_q  <= rad1_q;
      op2_q   <= op1_q;
      bsen2_q <= bsen1_q;
    end
  end

  // stage 3: compares
  logic [NT-1:0]         behind3_q;
  logic [PlaneCount-1:0] sph3_q;
  logic                  nov3_q, op3_q;
  localparam int unsigned CX = SW + FRACTION_BITS + 2;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int p = 0; p < PlaneCount; p++) begin
        for (int c = 0; c < CornerCount; c++)
          behind3_q[p*CornerCount+c] <= CX'(dot2_q[p*CornerCount+c])
                                        < (CX'(wd(plane_q[p], 3)) <<< FRACTION_BITS);
        sph3_q[p] <= CX'(dot2_q[NT+p]) - (CX'(wd(plane_q[p], 3)) <<< FRACTION_BITS)
                     < -(CX'(rad2_q) <<< FRACTION_BITS);
      end
      nov3_q <= bsen2_q && ((2*CW+5)'(d22_q) > rr2_q);
      op3_q  <= op2_q;
    end
  end

  // stage 4: result
  logic vis_q, visd;
  always_comb begin
    visd = 1'b1;
    if (op3_q == OpSphere) begin
      if (nov3_q || |sph3_q) visd = 1'b0;
    end else begin
      for (int p = 0; p < PlaneCount; p++)
        if (&behind3_q[p*CornerCount +: CornerCount]) visd = 1'b0;
    end
  end

  always_ff @(posedge clk_i) if (adv) vis_q <= visd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_if.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign out_if.valid   = v4_q;
  assign out_if.visible = vis_q;
endmodule

/* hdl/fcsb_checker.sv */
module fcsb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_visible_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_visible_i))
    else $error("result dropped while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while output blocked");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("pipeline stalled with empty output");
endmodule

bind frustum_cull_sphere_box fcsb_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .out_visible_i(out_if.visible)
);
